// ===== sv/fifo_page_table_assert.svh =====
// assertion macros for the fifo page table block
`ifndef FIFO_PAGE_TABLE_ASSERT_SVH
`define FIFO_PAGE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define FPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fifo_page_table assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define FPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fifo_page_table assertion failed");

`else

`define FPT_ASSERT_IMP(lbl, ante, cons)
`define FPT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/fpt_pkg.sv =====
// shared constants and types of the fifo page table block
package fpt_pkg;

  localparam int PAGES_DEFAULT  = 256;
  localparam int FRAMES_DEFAULT = 64;

  localparam int PAGE_NUM_W  = 8;
  localparam int MODE_W      = 2;
  localparam int FRAME_NUM_W = 6;
  localparam int CFG_W       = 7;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 7'd64;

  // register index as seen at paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  // page status codes
  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_RESIDENT = 2'd1;
  localparam logic [1:0] ST_ON_DISK  = 2'd2;

  // access modes
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd2;

  // status ram word: status code and dirty bit
  typedef struct packed {
    logic [1:0] status;
    logic       dirty;
  } page_info_t;

endpackage

// ===== sv/fpt_ifs.sv =====
// request and response channel interfaces of the fifo page table block
interface fpt_req_if;
  logic                            valid;
  logic                            ready;
  logic [fpt_pkg::PAGE_NUM_W-1:0]  page_number;
  logic [fpt_pkg::MODE_W-1:0]      access_mode;

  modport source (output valid, output page_number, output access_mode, input ready);
  modport sink   (input valid, input page_number, input access_mode, output ready);
endinterface

interface fpt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fpt_pkg::FRAME_NUM_W-1:0] frame_number;
  logic                            was_hit;
  logic                            evicted_valid;
  logic [fpt_pkg::PAGE_NUM_W-1:0]  victim_page;
  logic                            write_back;
  logic                            bad_page;

  modport source (output valid, output frame_number, output was_hit, output evicted_valid,
                  output victim_page, output write_back, output bad_page, input ready);
  modport sink   (input valid, input frame_number, input was_hit, input evicted_valid,
                  input victim_page, input write_back, input bad_page, output ready);
endinterface

// ===== sv/fpt_ram.sv =====
// generic single-write, single-read ram with registered read data
module fpt_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                  wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fifo_page_table.sv =====
// top level of the fifo page table block
//
// in_if carries one page reference per transfer (page_number, access_mode);
// out_if returns exactly one result per reference, in order. frames_in_use
// is set over the apb port at byte address 0; the user is to write it only
// while the block is idle, which the block itself does not enforce. each
// reference is worked by a small sequencer around three rams (page
// status/dirty, page frame, fifo ring), each with one read and one write
// port, so one reference is taken at a time:
//   bad page number: straight from S_IDLE to S_DONE
//   hit or miss on a never-used frame: S_LOOKUP, then S_DONE
//   miss with eviction: S_LOOKUP, S_VREAD (a second, registered status/frame
//   read for the victim), S_FILL, then S_DONE
// after reset the status ram is cleared one entry a cycle with in_if.ready
// low; apb writes are taken throughout. a finished result sits in the output
// register until out_if takes it; the block goes on with the next reference
// meanwhile and holds its following result only if the output register is full.
`include "fifo_page_table_assert.svh"

module fifo_page_table #(
  parameter int PAGES  = fpt_pkg::PAGES_DEFAULT,
  parameter int FRAMES = fpt_pkg::FRAMES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fpt_req_if.sink                       in_if,
  fpt_rsp_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpt_pkg::PADDR_W-1:0]   paddr,
  input  logic [fpt_pkg::PDATA_W-1:0]   pwdata,
  output logic [fpt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int UW = (CW > fpt_pkg::CFG_W) ? CW : fpt_pkg::CFG_W;
  localparam int IW = $bits(fpt_pkg::page_info_t);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_VREAD  = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration register
  logic [fpt_pkg::CFG_W-1:0] frames_in_use_r;
  logic                      cfg_wr;

  // control state
  logic [PW-1:0] clr_r, clr_nxt;
  logic [FW-1:0] head_r, head_nxt;
  logic [FW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] handed_r, handed_nxt;

  // current reference
  logic [PW-1:0] pno_r, pno_nxt;
  logic          wmode_r, wmode_nxt;
  logic [PW-1:0] victim_r, victim_nxt;
  logic [FW-1:0] frame_r, frame_nxt;

  // pending result
  logic [FW-1:0] res_frame_r, res_frame_nxt;
  logic          res_hit_r, res_hit_nxt;
  logic          res_evict_r, res_evict_nxt;
  logic          res_wb_r, res_wb_nxt;
  logic          res_bad_r, res_bad_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [fpt_pkg::FRAME_NUM_W-1:0]  out_frame_r, out_frame_nxt;
  logic                             out_hit_r, out_hit_nxt;
  logic                             out_evict_r, out_evict_nxt;
  logic [fpt_pkg::PAGE_NUM_W-1:0]   out_victim_r, out_victim_nxt;
  logic                             out_wb_r, out_wb_nxt;
  logic                             out_bad_r, out_bad_nxt;

  // ram ports
  logic                 info_we;
  logic [PW-1:0]        info_waddr, info_raddr;
  fpt_pkg::page_info_t  info_wdata, info_rdata;
  logic [IW-1:0]        info_rdata_raw;
  logic                 frm_we;
  logic [PW-1:0]        frm_waddr, frm_raddr;
  logic [FW-1:0]        frm_wdata, frm_rdata;
  logic                 ring_we;
  logic [PW-1:0]        ring_rdata;

  logic          in_xfer;
  logic          in_bad;
  logic [PW-1:0] in_idx;
  logic [UW-1:0] cfg_ext, usable;
  logic          free_frame;

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= fpt_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_wr && (paddr[2] == fpt_pkg::REG_FRAMES_IN_USE)) begin
      frames_in_use_r <= pwdata[fpt_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == fpt_pkg::REG_FRAMES_IN_USE)
                ? fpt_pkg::PDATA_W'(frames_in_use_r) : '0;

  // usable frames: register clamped to 1..FRAMES
  always_comb begin
    cfg_ext = UW'(frames_in_use_r);
    if (cfg_ext == '0) begin
      usable = UW'(1);
    end else if (cfg_ext > UW'(FRAMES)) begin
      usable = UW'(FRAMES);
    end else begin
      usable = cfg_ext;
    end
  end

  assign free_frame = UW'(handed_r) < usable;

  // ---------------------------------------------------------------- input side
  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign in_bad      = 32'(in_if.page_number) >= 32'(PAGES);
  assign in_idx      = PW'(in_if.page_number);

  // ---------------------------------------------------------------- rams
  assign info_rdata = fpt_pkg::page_info_t'(info_rdata_raw);

  fpt_ram #(.W(IW), .D(PAGES)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (IW'(info_wdata)),
    .raddr (info_raddr),
    .rdata (info_rdata_raw)
  );

  fpt_ram #(.W(FW), .D(PAGES)) u_frame_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  // ring is written at the tail, always read at the head
  fpt_ram #(.W(PW), .D(FRAMES)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (tail_r),
    .wdata (pno_r),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    handed_nxt     = handed_r;
    pno_nxt        = pno_r;
    wmode_nxt      = wmode_r;
    victim_nxt     = victim_r;
    frame_nxt      = frame_r;
    res_frame_nxt  = res_frame_r;
    res_hit_nxt    = res_hit_r;
    res_evict_nxt  = res_evict_r;
    res_wb_nxt     = res_wb_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r;
    out_frame_nxt  = out_frame_r;
    out_hit_nxt    = out_hit_r;
    out_evict_nxt  = out_evict_r;
    out_victim_nxt = out_victim_r;
    out_wb_nxt     = out_wb_r;
    out_bad_nxt    = out_bad_r;

    info_we           = 1'b0;
    info_waddr        = pno_r;
    info_wdata.status = fpt_pkg::ST_RESIDENT;
    info_wdata.dirty  = wmode_r;
    info_raddr        = in_idx;
    frm_we            = 1'b0;
    frm_waddr         = pno_r;
    frm_wdata         = frame_r;
    frm_raddr         = in_idx;
    ring_we           = 1'b0;

    // result taken by the sink frees the output register
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        info_we           = 1'b1;
        info_waddr        = clr_r;
        info_wdata.status = fpt_pkg::ST_UNUSED;
        info_wdata.dirty  = 1'b0;
        clr_nxt           = clr_r + PW'(1);
        if (clr_r == PW'(PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // status and frame reads of the requested page go out here
        if (in_xfer) begin
          pno_nxt       = in_idx;
          wmode_nxt     = (in_if.access_mode == fpt_pkg::MODE_WRITE);
          res_hit_nxt   = 1'b0;
          res_evict_nxt = 1'b0;
          res_wb_nxt    = 1'b0;
          res_frame_nxt = '0;
          res_bad_nxt   = in_bad;
          state_nxt     = in_bad ? S_DONE : S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        if (info_rdata.status == fpt_pkg::ST_RESIDENT) begin
          // hit: only a write touches the entry
          res_hit_nxt   = 1'b1;
          res_frame_nxt = frm_rdata;
          info_we       = wmode_r;
          info_wdata.dirty = 1'b1;
          state_nxt     = S_DONE;
        end else if (free_frame) begin
          // miss on a never-used frame
          res_frame_nxt = FW'(handed_r);
          handed_nxt    = handed_r + CW'(1);
          info_we       = 1'b1;
          frm_we        = 1'b1;
          frm_wdata     = FW'(handed_r);
          ring_we       = 1'b1;
          tail_nxt      = (tail_r == FW'(FRAMES - 1)) ? '0 : tail_r + FW'(1);
          state_nxt     = S_DONE;
        end else begin
          // miss with eviction: read the oldest page's entry
          victim_nxt    = ring_rdata;
          info_raddr    = ring_rdata;
          frm_raddr     = ring_rdata;
          res_evict_nxt = 1'b1;
          state_nxt     = S_VREAD;
        end
      end

      S_VREAD: begin
        // victim goes to disk if dirty, else back to unused
        res_wb_nxt        = info_rdata.dirty;
        res_frame_nxt     = frm_rdata;
        frame_nxt         = frm_rdata;
        info_we           = 1'b1;
        info_waddr        = victim_r;
        info_wdata.status = info_rdata.dirty ? fpt_pkg::ST_ON_DISK : fpt_pkg::ST_UNUSED;
        info_wdata.dirty  = 1'b0;
        head_nxt          = (head_r == FW'(FRAMES - 1)) ? '0 : head_r + FW'(1);
        state_nxt         = S_FILL;
      end

      S_FILL: begin
        // reload into the freed frame
        info_we   = 1'b1;
        frm_we    = 1'b1;
        ring_we   = 1'b1;
        tail_nxt  = (tail_r == FW'(FRAMES - 1)) ? '0 : tail_r + FW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hand over to the output register once it is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = fpt_pkg::FRAME_NUM_W'(res_frame_r);
          out_hit_nxt    = res_hit_r;
          out_evict_nxt  = res_evict_r;
          out_victim_nxt = res_evict_r ? fpt_pkg::PAGE_NUM_W'(victim_r) : '0;
          out_wb_nxt     = res_wb_r;
          out_bad_nxt    = res_bad_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      handed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      handed_r    <= handed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pno_r        <= pno_nxt;
    wmode_r      <= wmode_nxt;
    victim_r     <= victim_nxt;
    frame_r      <= frame_nxt;
    res_frame_r  <= res_frame_nxt;
    res_hit_r    <= res_hit_nxt;
    res_evict_r  <= res_evict_nxt;
    res_wb_r     <= res_wb_nxt;
    res_bad_r    <= res_bad_nxt;
    out_frame_r  <= out_frame_nxt;
    out_hit_r    <= out_hit_nxt;
    out_evict_r  <= out_evict_nxt;
    out_victim_r <= out_victim_nxt;
    out_wb_r     <= out_wb_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  // ---------------------------------------------------------------- output side
  assign out_if.valid         = out_valid_r;
  assign out_if.frame_number  = out_frame_r;
  assign out_if.was_hit       = out_hit_r;
  assign out_if.evicted_valid = out_evict_r;
  assign out_if.victim_page   = out_victim_r;
  assign out_if.write_back    = out_wb_r;
  assign out_if.bad_page      = out_bad_r;

  // ---------------------------------------------------------------- assertions
  `FPT_ASSERT_IMP(a_handed_bound, 1'b1, handed_r <= CW'(FRAMES))
  `FPT_ASSERT_NXT(a_accept_next, in_xfer, state_r == S_LOOKUP || state_r == S_DONE)
  `FPT_ASSERT_IMP(a_vread_from_lookup, state_r == S_VREAD, $past(state_r) == S_LOOKUP)
  `FPT_ASSERT_IMP(a_hit_no_evict, out_if.valid && out_if.was_hit, !out_if.evicted_valid)
  `FPT_ASSERT_IMP(a_wb_needs_evict, out_if.valid && out_if.write_back, out_if.evicted_valid)

endmodule
